// ===== hdl/nzt_pkg.sv =====
// Shared types, codes and helpers for the nested zone timing tracer.
// Used by every RTL file of the block; depends on nothing.
`default_nettype none

package nzt_pkg;

    localparam int REQ_W   = 3;
    localparam int ID_W    = 16;
    localparam int TS_W    = 32;
    localparam int NEST_W  = 16;
    localparam int LEVEL_W = 4;
    localparam int CNT_W   = 32;
    localparam int CAP_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int MAX_NEST_DEF = 16;
    localparam int LONG_CAP_DEF = 64;

    localparam logic             TRACE_EN_RST = 1'b1;
    localparam logic [TS_W-1:0]  LONG_THR_RST = 32'd16000;
    localparam logic [CAP_W-1:0] ZONE_CAP_RST = 16'd1024;
    localparam logic [NEST_W-1:0] NEST_MAX    = 16'hFFFF;

    typedef enum logic [REQ_W-1:0] {
        REQ_FRAME_BEGIN = 3'd0,
        REQ_FRAME_END   = 3'd1,
        REQ_ZONE_BEGIN  = 3'd2,
        REQ_ZONE_END    = 3'd3,
        REQ_CLEAR       = 3'd4
    } req_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRACE_ENABLED  = 2'd0,
        CFG_LONG_THRESHOLD = 2'd1,
        CFG_ZONE_CAPACITY  = 2'd2
    } cfg_index_t;

    // Decisions taken by the stack stage for one transfer, handed to the
    // sample stage together with the entry read from the stack.
    typedef struct packed {
        logic [REQ_W-1:0]   req;
        logic               deep_drop;
        logic               end_unmatched;
        logic               sample;
        logic [LEVEL_W-1:0] level;
        logic [NEST_W-1:0]  close_count;
        logic [TS_W-1:0]    ts;
    } nzt_ctl_t;

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== hdl/nzt_req_if.sv =====
// Input channel of the tracer: valid/ready handshake with one trace event.
// Depends on nzt_pkg for the field widths.
`default_nettype none

interface nzt_req_if
    import nzt_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [REQ_W-1:0]  req_type;
    logic [ID_W-1:0]   zone_id;
    logic [TS_W-1:0]   timestamp;

    modport source (output valid, output req_type, output zone_id, output timestamp,
                    input ready);
    modport sink   (input valid, input req_type, input zone_id, input timestamp,
                    output ready);
endinterface

`default_nettype wire

// ===== hdl/nzt_res_if.sv =====
// Result channel of the tracer: valid/ready handshake with one sample record.
// Depends on nzt_pkg for the field widths.
`default_nettype none

interface nzt_res_if
    import nzt_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               sample_valid;
    logic [ID_W-1:0]    sample_zone;
    logic [TS_W-1:0]    start_offset;
    logic [TS_W-1:0]    duration;
    logic [LEVEL_W-1:0] nest_level;
    logic               is_long;
    logic               long_kept;
    logic               sample_kept;
    logic [CNT_W-1:0]   dropped_total;
    logic [CNT_W-1:0]   unbalanced_total;
    logic [CNT_W-1:0]   long_total;
    logic [CNT_W-1:0]   frame_count;

    modport source (output valid, output sample_valid, output sample_zone,
                    output start_offset, output duration, output nest_level,
                    output is_long, output long_kept, output sample_kept,
                    output dropped_total, output unbalanced_total,
                    output long_total, output frame_count,
                    input ready);
    modport sink   (input valid, input sample_valid, input sample_zone,
                    input start_offset, input duration, input nest_level,
                    input is_long, input long_kept, input sample_kept,
                    input dropped_total, input unbalanced_total,
                    input long_total, input frame_count,
                    output ready);
endinterface

`default_nettype wire

// ===== hdl/nzt_zone_stack.sv =====
// Zone stack of the tracer: nesting depth register and the id/start memory.
// Decides push, pop and depth handling per transfer. Depends on nzt_pkg.
`default_nettype none

module nzt_zone_stack
    import nzt_pkg::*;
#(
    parameter int MAX_NEST = MAX_NEST_DEF
)(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic              trace_enabled,
    input  wire logic [REQ_W-1:0]  req_type,
    input  wire logic [ID_W-1:0]   zone_id,
    input  wire logic [TS_W-1:0]   timestamp,
    output nzt_ctl_t               ctl,
    output logic [ID_W-1:0]        rd_id,
    output logic [TS_W-1:0]        rd_start
);

    localparam int AW = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;
    localparam logic [NEST_W-1:0] DEPTH = NEST_W'(MAX_NEST);

    logic [ID_W+TS_W-1:0] mem [MAX_NEST];

    logic [NEST_W-1:0] nesting_reg;
    logic [NEST_W-1:0] nesting_next;
    logic [NEST_W-1:0] depth_below;
    logic              wr_en;
    logic              rd_en;
    logic [AW-1:0]     addr;

    assign depth_below = nesting_reg - NEST_W'(1);

    always_comb
    begin
        ctl               = '0;
        ctl.req           = req_type;
        ctl.ts            = timestamp;
        nesting_next      = nesting_reg;
        wr_en             = 1'b0;
        rd_en             = 1'b0;
        addr              = '0;
        case (req_type)
            REQ_FRAME_BEGIN, REQ_FRAME_END:
            begin
                ctl.close_count = nesting_reg;
                nesting_next    = '0;
            end
            REQ_ZONE_BEGIN:
            begin
                if (trace_enabled)
                begin
                    if (nesting_reg != NEST_MAX)
                    begin
                        nesting_next = nesting_reg + NEST_W'(1);
                    end
                    if (nesting_reg >= DEPTH)
                    begin
                        ctl.deep_drop = 1'b1;
                    end
                    else
                    begin
                        wr_en = 1'b1;
                        addr  = nesting_reg[AW-1:0];
                    end
                end
            end
            REQ_ZONE_END:
            begin
                if (trace_enabled)
                begin
                    if (nesting_reg == '0)
                    begin
                        ctl.end_unmatched = 1'b1;
                    end
                    else
                    begin
                        nesting_next = depth_below;
                        if (depth_below < DEPTH)
                        begin
                            ctl.sample = 1'b1;
                            ctl.level  = depth_below[LEVEL_W-1:0];
                            rd_en      = 1'b1;
                            addr       = depth_below[AW-1:0];
                        end
                    end
                end
            end
            REQ_CLEAR:
            begin
                nesting_next = '0;
            end
            default:
            begin
                nesting_next = nesting_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nesting_reg <= '0;
        end
        else if (accept)
        begin
            nesting_reg <= nesting_next;
        end
    end

    // A pop reads the entry a push wrote at least one transfer earlier, so the
    // registered read never needs a bypass.
    always_ff @(posedge clk)
    begin
        if (accept && wr_en)
        begin
            mem[addr] <= {zone_id, timestamp};
        end
        if (accept && rd_en)
        begin
            {rd_id, rd_start} <= mem[addr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/nested_zone_timing_tracer.sv =====
// Nested zone timing tracer: every trace event transfer returns one result
// record, and a new event can be taken in every cycle while the result side
// keeps up. The stack stage updates the nesting depth and pushes to or reads
// from the zone stack memory, whose read data is registered; the result
// stage then computes offset, duration, long and capacity flags and the
// running counters into the result register. Throughput is one event per
// cycle, limited only by the ready of the result channel.
// Top level; depends on nzt_pkg, nzt_req_if, nzt_res_if and nzt_zone_stack.
`default_nettype none

module nested_zone_timing_tracer
    import nzt_pkg::*;
#(
    parameter int MAX_NEST = MAX_NEST_DEF,
    parameter int LONG_CAP = LONG_CAP_DEF
)(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    nzt_req_if.sink                    req,
    nzt_res_if.source                  res,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int LW = $clog2(LONG_CAP + 1);
    localparam logic [LW-1:0] LONG_LIMIT = LW'(LONG_CAP);

    // Configuration registers.
    logic             trace_enabled_reg;
    logic [TS_W-1:0]  long_threshold_reg;
    logic [CAP_W-1:0] zone_capacity_reg;

    // Per-frame and running state.
    logic [TS_W-1:0]  frame_origin_reg,  frame_origin_next;
    logic [CAP_W-1:0] kept_in_frame_reg, kept_in_frame_next;
    logic [LW-1:0]    long_in_frame_reg, long_in_frame_next;
    logic [CNT_W-1:0] drop_reg,          drop_next;
    logic [CNT_W-1:0] unmatched_reg,     unmatched_next;
    logic [CNT_W-1:0] long_cnt_reg,      long_cnt_next;
    logic [CNT_W-1:0] frames_reg,        frames_next;

    // Stage between stack and result register.
    logic      s1_valid_reg;
    nzt_ctl_t  ctl_in;
    nzt_ctl_t  s1_ctl_reg;
    logic [ID_W-1:0] rd_id;
    logic [TS_W-1:0] rd_start;

    logic accept;
    logic out_load;
    logic cfg_cap_write;

    // Result register.
    logic               res_valid_reg;
    logic               sample_valid_reg,  sample_valid_next;
    logic [ID_W-1:0]    sample_zone_reg,   sample_zone_next;
    logic [TS_W-1:0]    start_offset_reg,  start_offset_next;
    logic [TS_W-1:0]    duration_reg,      duration_next;
    logic [LEVEL_W-1:0] nest_level_reg,    nest_level_next;
    logic               is_long_reg,       is_long_next;
    logic               long_kept_reg,     long_kept_next;
    logic               sample_kept_reg,   sample_kept_next;

    logic [TS_W-1:0]  dur;
    logic [CAP_W-1:0] cap;

    assign out_load = s1_valid_reg && (!res_valid_reg || res.ready);
    assign req.ready = !s1_valid_reg || out_load;
    assign accept    = req.valid && req.ready;
    assign cfg_cap_write = cfg_we && (cfg_index == CFG_ZONE_CAPACITY);

    nzt_zone_stack #(
        .MAX_NEST (MAX_NEST)
    ) u_stack (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .trace_enabled (trace_enabled_reg),
        .req_type      (req.req_type),
        .zone_id       (req.zone_id),
        .timestamp     (req.timestamp),
        .ctl           (ctl_in),
        .rd_id         (rd_id),
        .rd_start      (rd_start)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trace_enabled_reg  <= TRACE_EN_RST;
            long_threshold_reg <= LONG_THR_RST;
            zone_capacity_reg  <= ZONE_CAP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TRACE_ENABLED:  trace_enabled_reg  <= cfg_data[0];
                CFG_LONG_THRESHOLD: long_threshold_reg <= cfg_data[TS_W-1:0];
                CFG_ZONE_CAPACITY:  zone_capacity_reg  <= cfg_data[CAP_W-1:0];
                default:            trace_enabled_reg  <= trace_enabled_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ctl_reg <= ctl_in;
        end
    end

    assign dur = s1_ctl_reg.ts - rd_start;
    assign cap = (zone_capacity_reg == '0) ? CAP_W'(1) : zone_capacity_reg;

    always_comb
    begin
        frame_origin_next  = frame_origin_reg;
        kept_in_frame_next = kept_in_frame_reg;
        long_in_frame_next = long_in_frame_reg;
        drop_next          = drop_reg;
        unmatched_next     = unmatched_reg;
        long_cnt_next      = long_cnt_reg;
        frames_next        = frames_reg;
        sample_valid_next  = 1'b0;
        sample_zone_next   = '0;
        start_offset_next  = '0;
        duration_next      = '0;
        nest_level_next    = '0;
        is_long_next       = 1'b0;
        long_kept_next     = 1'b0;
        sample_kept_next   = 1'b0;
        case (s1_ctl_reg.req)
            REQ_FRAME_BEGIN:
            begin
                unmatched_next     = sat_add(unmatched_reg,
                                             CNT_W'(s1_ctl_reg.close_count));
                kept_in_frame_next = '0;
                long_in_frame_next = '0;
                frame_origin_next  = s1_ctl_reg.ts;
            end
            REQ_FRAME_END:
            begin
                unmatched_next = sat_add(unmatched_reg,
                                         CNT_W'(s1_ctl_reg.close_count));
                frames_next    = frames_reg + CNT_W'(1);
            end
            REQ_ZONE_BEGIN:
            begin
                if (s1_ctl_reg.deep_drop)
                begin
                    drop_next = sat_add(drop_reg, CNT_W'(1));
                end
            end
            REQ_ZONE_END:
            begin
                if (s1_ctl_reg.end_unmatched)
                begin
                    unmatched_next = sat_add(unmatched_reg, CNT_W'(1));
                end
                if (s1_ctl_reg.sample)
                begin
                    sample_valid_next = 1'b1;
                    sample_zone_next  = rd_id;
                    start_offset_next = rd_start - frame_origin_reg;
                    duration_next     = dur;
                    nest_level_next   = s1_ctl_reg.level;
                    if (dur >= long_threshold_reg)
                    begin
                        is_long_next  = 1'b1;
                        long_cnt_next = sat_add(long_cnt_reg, CNT_W'(1));
                        if (long_in_frame_reg < LONG_LIMIT)
                        begin
                            long_kept_next     = 1'b1;
                            long_in_frame_next = long_in_frame_reg + LW'(1);
                        end
                    end
                    if (kept_in_frame_reg < cap)
                    begin
                        sample_kept_next   = 1'b1;
                        kept_in_frame_next = kept_in_frame_reg + CAP_W'(1);
                    end
                    else
                    begin
                        drop_next = sat_add(drop_reg, CNT_W'(1));
                    end
                end
            end
            REQ_CLEAR:
            begin
                kept_in_frame_next = '0;
                long_in_frame_next = '0;
                drop_next          = '0;
                unmatched_next     = '0;
                long_cnt_next      = '0;
                frames_next        = '0;
                frame_origin_next  = s1_ctl_reg.ts;
            end
            default:
            begin
                sample_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_origin_reg  <= '0;
            kept_in_frame_reg <= '0;
            long_in_frame_reg <= '0;
            drop_reg          <= '0;
            unmatched_reg     <= '0;
            long_cnt_reg      <= '0;
            frames_reg        <= '0;
        end
        else if (out_load)
        begin
            frame_origin_reg  <= frame_origin_next;
            kept_in_frame_reg <= kept_in_frame_next;
            long_in_frame_reg <= long_in_frame_next;
            drop_reg          <= drop_next;
            unmatched_reg     <= unmatched_next;
            long_cnt_reg      <= long_cnt_next;
            frames_reg        <= frames_next;
        end
        else if (cfg_cap_write)
        begin
            // A new zone capacity restarts the per-frame kept count when no result is being loaded.
            kept_in_frame_reg <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            sample_valid_reg <= sample_valid_next;
            sample_zone_reg  <= sample_zone_next;
            start_offset_reg <= start_offset_next;
            duration_reg     <= duration_next;
            nest_level_reg   <= nest_level_next;
            is_long_reg      <= is_long_next;
            long_kept_reg    <= long_kept_next;
            sample_kept_reg  <= sample_kept_next;
        end
    end

    assign res.valid            = res_valid_reg;
    assign res.sample_valid     = sample_valid_reg;
    assign res.sample_zone      = sample_zone_reg;
    assign res.start_offset     = start_offset_reg;
    assign res.duration         = duration_reg;
    assign res.nest_level       = nest_level_reg;
    assign res.is_long          = is_long_reg;
    assign res.long_kept        = long_kept_reg;
    assign res.sample_kept      = sample_kept_reg;
    assign res.dropped_total    = drop_reg;
    assign res.unbalanced_total = unmatched_reg;
    assign res.long_total       = long_cnt_reg;
    assign res.frame_count      = frames_reg;

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for the nested zone timing tracer.
// Depends on nzt_pkg, nzt_req_if, nzt_res_if and nested_zone_timing_tracer;
// the expected records come from a predictor that lives in this file.
`default_nettype none

module tb;
    import nzt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 1_500_000;
    localparam int          DRAIN_CYCLES = 6;
    localparam int          HOLD_CYCLES  = 150;
    localparam int          REPORT_CAP   = 50;

    typedef struct packed {
        bit               sample_valid;
        bit [ID_W-1:0]    sample_zone;
        bit [TS_W-1:0]    start_offset;
        bit [TS_W-1:0]    duration;
        bit [LEVEL_W-1:0] nest_level;
        bit               is_long;
        bit               long_kept;
        bit               sample_kept;
        bit [CNT_W-1:0]   dropped_total;
        bit [CNT_W-1:0]   unbalanced_total;
        bit [CNT_W-1:0]   long_total;
        bit [CNT_W-1:0]   frame_count;
    } trace_rec_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    nzt_req_if req_ch();
    nzt_res_if res_ch();

    nested_zone_timing_tracer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Predictor state: zone stack, frame bookkeeping, counters and registers.
    bit [ID_W-1:0]   stk_id    [MAX_NEST_DEF];
    bit [TS_W-1:0]   stk_start [MAX_NEST_DEF];
    bit [NEST_W-1:0] open_depth;
    bit [TS_W-1:0]   origin_ts;
    bit [CAP_W-1:0]  kept_this_frame;
    bit [6:0]        long_this_frame;
    bit [CNT_W-1:0]  drops, unbalanced, longs, frames;
    bit              trace_on;
    bit [TS_W-1:0]   long_thr;
    bit [CAP_W-1:0]  zone_cap;

    trace_rec_t  awaited_records[$];
    int unsigned failures;
    int unsigned events_sent;
    int unsigned records_checked;
    int unsigned samples_seen;
    int unsigned long_samples;
    int unsigned cycle_count;
    bit          tx_random;
    bit          rx_random;
    bit          hold_off_pending;
    bit [TS_W-1:0] now_ts;

    function automatic bit [CNT_W-1:0] sat_sum(bit [CNT_W-1:0] a, bit [CNT_W-1:0] b);
        bit [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? '1 : s[CNT_W-1:0];
    endfunction

    // Applies one accepted event to the predictor state and returns the record
    // the block must produce for it.
    function automatic trace_rec_t compute_trace_record(logic [REQ_W-1:0] kind,
                                                        logic [ID_W-1:0] id,
                                                        logic [TS_W-1:0] ts);
        trace_rec_t     r;
        int unsigned    idx;
        bit [CAP_W-1:0] eff_cap;
        r = '0;
        case (kind)
            REQ_FRAME_BEGIN:
            begin
                unbalanced      = sat_sum(unbalanced, open_depth);
                open_depth      = '0;
                kept_this_frame = '0;
                long_this_frame = '0;
                origin_ts       = ts;
            end
            REQ_FRAME_END:
            begin
                unbalanced = sat_sum(unbalanced, open_depth);
                open_depth = '0;
                frames     = frames + 1;
            end
            REQ_ZONE_BEGIN:
            begin
                if (trace_on)
                begin
                    idx = open_depth;
                    if (open_depth != NEST_MAX)
                        open_depth = open_depth + 1;
                    if (idx >= MAX_NEST_DEF)
                        drops = sat_sum(drops, 1);
                    else
                    begin
                        stk_id[idx]    = id;
                        stk_start[idx] = ts;
                    end
                end
            end
            REQ_ZONE_END:
            begin
                if (trace_on)
                begin
                    if (open_depth == 0)
                        unbalanced = sat_sum(unbalanced, 1);
                    else
                    begin
                        open_depth = open_depth - 1;
                        idx = open_depth;
                        // Zones that went past the stack only unwind the depth.
                        if (idx < MAX_NEST_DEF)
                        begin
                            eff_cap        = (zone_cap == 0) ? 1 : zone_cap;
                            r.sample_valid = 1'b1;
                            r.sample_zone  = stk_id[idx];
                            r.start_offset = stk_start[idx] - origin_ts;
                            r.duration     = ts - stk_start[idx];
                            r.nest_level   = idx[LEVEL_W-1:0];
                            if (r.duration >= long_thr)
                            begin
                                r.is_long = 1'b1;
                                longs     = sat_sum(longs, 1);
                                if (long_this_frame < LONG_CAP_DEF)
                                begin
                                    r.long_kept     = 1'b1;
                                    long_this_frame = long_this_frame + 1;
                                end
                            end
                            if (kept_this_frame < eff_cap)
                            begin
                                r.sample_kept   = 1'b1;
                                kept_this_frame = kept_this_frame + 1;
                            end
                            else
                                drops = sat_sum(drops, 1);
                        end
                    end
                end
            end
            REQ_CLEAR:
            begin
                open_depth      = '0;
                kept_this_frame = '0;
                long_this_frame = '0;
                drops           = '0;
                unbalanced      = '0;
                longs           = '0;
                frames          = '0;
                origin_ts       = ts;
            end
            default: ;
        endcase
        r.dropped_total    = drops;
        r.unbalanced_total = unbalanced;
        r.long_total       = longs;
        r.frame_count      = frames;
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            failures++;
            // Past REPORT_CAP reports the count alone keeps the log readable.
            if (failures <= REPORT_CAP)
                $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
        end
    endfunction

    // Mostly back to back, often a short pause, now and then a long one.
    function automatic int pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else if (roll < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Run stopped at the cycle limit with %0d records outstanding.",
                     awaited_records.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial
    begin
        int stall_left;
        stall_left = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end
            else if (hold_off_pending)
            begin
                hold_off_pending = 1'b0;
                stall_left = HOLD_CYCLES - 1;
                res_ch.ready <= 1'b0;
            end
            else if (rx_random && $urandom_range(0, 3) == 0)
            begin
                stall_left = (pick_gap() > 10) ? $urandom_range(20, 60) : $urandom_range(0, 2);
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        trace_rec_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (awaited_records.size() == 0)
            begin
                failures++;
                $error("result transfer arrived with no record expected");
            end
            else
            begin
                want = awaited_records.pop_front();
                check_field("sample_valid", want.sample_valid, res_ch.sample_valid);
                check_field("sample_zone", want.sample_zone, res_ch.sample_zone);
                check_field("start_offset", want.start_offset, res_ch.start_offset);
                check_field("duration", want.duration, res_ch.duration);
                check_field("nest_level", want.nest_level, res_ch.nest_level);
                check_field("is_long", want.is_long, res_ch.is_long);
                check_field("long_kept", want.long_kept, res_ch.long_kept);
                check_field("sample_kept", want.sample_kept, res_ch.sample_kept);
                check_field("dropped_total", want.dropped_total, res_ch.dropped_total);
                check_field("unbalanced_total", want.unbalanced_total,
                            res_ch.unbalanced_total);
                check_field("long_total", want.long_total, res_ch.long_total);
                check_field("frame_count", want.frame_count, res_ch.frame_count);
                records_checked++;
                if (want.sample_valid)
                    samples_seen++;
                if (want.is_long)
                    long_samples++;
            end
        end
    end

    // Called at a clock edge; returns at the edge where the transfer happened.
    // Valid stays high into the next call when no gap is chosen.
    task automatic send_event(logic [REQ_W-1:0] kind, logic [ID_W-1:0] id,
                              logic [TS_W-1:0] ts);
        int gap;
        trace_rec_t rec;
        gap = tx_random ? pick_gap() : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= kind;
        req_ch.zone_id   <= id;
        req_ch.timestamp <= ts;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        rec = compute_trace_record(kind, id, ts);
        awaited_records.insert(awaited_records.size(), rec);
        events_sent++;
    endtask

    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (awaited_records.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_TRACE_ENABLED:  trace_on = data[0];
            CFG_LONG_THRESHOLD: long_thr = data;
            CFG_ZONE_CAPACITY:
            begin
                zone_cap        = data[CAP_W-1:0];
                kept_this_frame = '0;
            end
            default: ;
        endcase
    endtask

    // Unused upper bits of the narrow registers carry random junk.
    task automatic set_config(bit en, logic [TS_W-1:0] thr, logic [CAP_W-1:0] cap);
        wait_drained();
        write_reg(CFG_TRACE_ENABLED, {31'($urandom), en});
        write_reg(CFG_LONG_THRESHOLD, thr);
        write_reg(CFG_ZONE_CAPACITY, {16'($urandom), cap});
    endtask

    task automatic advance_time();
        if ($urandom_range(0, 15) == 0)
            now_ts = now_ts + $urandom;
        else
            now_ts = now_ts + $urandom_range(0, 40);
    endtask

    task automatic zone_pair(logic [ID_W-1:0] id, logic [TS_W-1:0] t0, logic [TS_W-1:0] t1);
        send_event(REQ_ZONE_BEGIN, id, t0);
        send_event(REQ_ZONE_END, $urandom_range(0, 16'hFFFF), t1);
    endtask

    task automatic test_basic_events();
        send_event(REQ_ZONE_END, 16'h0000, 32'h0000_0010);
        send_event(REQ_FRAME_BEGIN, 16'hFFFF, 32'hFFFF_FF00);
        send_event(REQ_ZONE_BEGIN, 16'hFFFF, 32'hFFFF_FF10);
        send_event(REQ_ZONE_BEGIN, 16'h0000, 32'hFFFF_FFFF);
        // Inner zone ends after the timestamp has wrapped.
        send_event(REQ_ZONE_END, 16'h1234, 32'h0000_0005);
        send_event(REQ_ZONE_BEGIN, 16'hA5A5, 32'h0000_0010);
        send_event(3'd5, 16'hFFFF, 32'hFFFF_FFFF);
        send_event(3'd6, 16'h0000, 32'h0000_0000);
        send_event(3'd7, 16'h5A5A, 32'h1234_5678);
        send_event(REQ_ZONE_END, 16'h0000, 32'h0000_4000);
        // Duration exactly at the reset threshold of 16000 ticks.
        send_event(REQ_ZONE_END, 16'h0000, 32'h0000_3D90);
        zone_pair(16'h5A5A, 32'h0000_4000, 32'h0000_4000 + 32'd15999);
        send_event(REQ_ZONE_BEGIN, 16'h0F0F, 32'h0000_9000);
        send_event(REQ_FRAME_END, 16'h0000, 32'h0000_9100);
        send_event(REQ_ZONE_BEGIN, 16'hF0F0, 32'h0000_9200);
        send_event(REQ_ZONE_BEGIN, 16'h00FF, 32'h0000_9300);
        send_event(REQ_FRAME_BEGIN, 16'h0000, 32'h0000_9400);
        send_event(REQ_CLEAR, 16'hFFFF, 32'h8765_4321);
        send_event(REQ_ZONE_END, 16'h0000, 32'h8765_4400);
        send_event(REQ_FRAME_END, 16'h0000, 32'h8765_4500);
    endtask

    task automatic test_trace_disabled();
        wait_drained();
        write_reg(CFG_TRACE_ENABLED, 32'hFFFF_FFFE);
        send_event(REQ_FRAME_BEGIN, 16'h0001, 32'h0000_1000);
        send_event(REQ_ZONE_BEGIN, 16'h0002, 32'h0000_1010);
        send_event(REQ_ZONE_END, 16'h0003, 32'h0000_1020);
        send_event(REQ_ZONE_END, 16'h0004, 32'h0000_1030);
        send_event(REQ_FRAME_END, 16'h0005, 32'h0000_1040);
        wait_drained();
        write_reg(CFG_TRACE_ENABLED, 32'h0000_0001);
        zone_pair(16'h0006, 32'h0000_1050, 32'h0000_1060);
    endtask

    task automatic test_too_deep();
        send_event(REQ_FRAME_BEGIN, 16'h0000, 32'h0010_0000);
        for (int i = 0; i < MAX_NEST_DEF + 2; i++)
            send_event(REQ_ZONE_BEGIN, $urandom_range(0, 16'hFFFF), 32'h0010_0000 + i * 7);
        for (int i = 0; i < MAX_NEST_DEF + 2; i++)
            send_event(REQ_ZONE_END, 16'h0000, 32'h0010_0100 + i * 3);
        send_event(REQ_FRAME_END, 16'h0000, 32'h0010_0200);
    endtask

    task automatic test_capacity_limits();
        // A capacity of zero behaves like a capacity of one.
        set_config(1'b1, 32'd16000, 16'd0);
        send_event(REQ_FRAME_BEGIN, 16'h0000, 32'h0020_0000);
        for (int i = 0; i < 3; i++)
            zone_pair(i, 32'h0020_0010 + i * 16, 32'h0020_0018 + i * 16);
        set_config(1'b1, 32'd16000, 16'd2);
        send_event(REQ_FRAME_BEGIN, 16'h0000, 32'h0021_0000);
        for (int i = 0; i < 3; i++)
            zone_pair(i, 32'h0021_0010 + i * 16, 32'h0021_0018 + i * 16);
        // Rewriting the capacity mid-frame restarts the kept count.
        set_config(1'b1, 32'd16000, 16'd1);
        zone_pair(16'h0077, 32'h0021_0100, 32'h0021_0110);
        zone_pair(16'h0078, 32'h0021_0200, 32'h0021_0210);
        set_config(1'b1, 32'd16000, 16'hFFFF);
        zone_pair(16'h0079, 32'h0021_0300, 32'h0021_0310);
    endtask

    task automatic test_long_capacity();
        set_config(1'b1, 32'd0, 16'hFFFF);
        send_event(REQ_FRAME_BEGIN, 16'h0000, 32'h0030_0000);
        for (int i = 0; i < LONG_CAP_DEF + 6; i++)
            zone_pair($urandom_range(0, 16'hFFFF), 32'h0030_0000 + i * 8,
                      32'h0030_0004 + i * 8);
        // With the largest threshold only a duration of all ones is long.
        set_config(1'b1, 32'hFFFF_FFFF, 16'd1024);
        send_event(REQ_FRAME_BEGIN, 16'h0000, 32'h0000_0000);
        zone_pair(16'h1111, 32'h0000_0001, 32'h0000_0000);
        zone_pair(16'h2222, 32'h0000_0002, 32'h0000_0000);
    endtask

    task automatic test_backpressure();
        bit tx_keep;
        tx_keep = tx_random;
        tx_random = 1'b0;
        wait_drained();
        hold_off_pending = 1'b1;
        send_event(REQ_FRAME_BEGIN, 16'h0000, now_ts);
        for (int i = 0; i < 20; i++)
        begin
            advance_time();
            zone_pair($urandom_range(0, 16'hFFFF), now_ts, now_ts + $urandom_range(0, 200));
        end
        tx_random = tx_keep;
    endtask

    task automatic send_noise();
        logic [REQ_W-1:0] kind;
        kind = $urandom_range(0, 7);
        send_event(kind, $urandom_range(0, 16'hFFFF), ($urandom_range(0, 3) == 0) ? $urandom : now_ts);
    endtask

    // One frame of well-formed nesting with random ids and times, with a
    // little noise mixed in and sometimes zones left open at the frame end.
    task automatic run_random_frame(int steps);
        int depth_now;
        int depth_cap;
        depth_now = 0;
        depth_cap = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 5);
        tx_random = ($urandom_range(0, 4) != 0);
        rx_random = ($urandom_range(0, 4) != 0);
        advance_time();
        send_event(REQ_FRAME_BEGIN, $urandom_range(0, 16'hFFFF), now_ts);
        for (int i = 0; i < steps; i++)
        begin
            advance_time();
            if ($urandom_range(0, 19) == 0)
                send_noise();
            else if (depth_now == 0 || (depth_now < depth_cap && $urandom_range(0, 1) == 1))
            begin
                send_event(REQ_ZONE_BEGIN, $urandom_range(0, 16'hFFFF), now_ts);
                depth_now++;
            end
            else
            begin
                send_event(REQ_ZONE_END, $urandom_range(0, 16'hFFFF), now_ts);
                depth_now--;
            end
        end
        if ($urandom_range(0, 4) != 0)
        begin
            while (depth_now > 0)
            begin
                advance_time();
                send_event(REQ_ZONE_END, $urandom_range(0, 16'hFFFF), now_ts);
                depth_now--;
            end
        end
        advance_time();
        send_event(REQ_FRAME_END, $urandom_range(0, 16'hFFFF), now_ts);
    endtask

    task automatic random_phase(int unsigned count);
        int unsigned first;
        first = events_sent;
        while (events_sent - first < count)
            run_random_frame($urandom_range(4, 24));
    endtask

    task automatic test_random_traffic();
        now_ts = $urandom;
        set_config(1'b1, 32'd16000, 16'd1024);
        random_phase(100);
        set_config(1'b1, $urandom_range(8, 120), $urandom_range(1, 6));
        random_phase(100);
        set_config(1'b1, 32'd0, 16'd0);
        random_phase(90);
        set_config(1'b1, 32'hFFFF_FFFF, 16'hFFFF);
        random_phase(90);
        set_config(1'b1, $urandom, $urandom_range(1, 16'hFFFF));
        random_phase(90);
        set_config(1'b0, $urandom_range(0, 60), 16'd3);
        random_phase(30);
        set_config(1'b1, $urandom_range(0, 60), $urandom_range(1, 4));
        random_phase(100);
    endtask

    initial
    begin
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_index        <= '0;
        cfg_data         <= '0;
        req_ch.valid     <= 1'b0;
        req_ch.req_type  <= '0;
        req_ch.zone_id   <= '0;
        req_ch.timestamp <= '0;
        trace_on  = TRACE_EN_RST;
        long_thr  = LONG_THR_RST;
        zone_cap  = ZONE_CAP_RST;
        tx_random = 1'b1;
        rx_random = 1'b1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_events();
        test_trace_disabled();
        test_too_deep();
        test_capacity_limits();
        test_long_capacity();
        test_backpressure();
        test_random_traffic();

        wait_drained();
        $display("Sent %0d trace events; checked %0d result records.",
                 events_sent, records_checked);
        $display("Timed samples seen: %0d, of which long: %0d; field mismatches: %0d.",
                 samples_seen, long_samples, failures);
        if (failures == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
